// ===== hw/rtl/rtck_pkg.sv =====
// Shared types and constants of the run-time clock and key toggle block.
package rtck_pkg;

    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_POWER_KEY   = 2'd1;
    localparam logic [1:0] OP_RADIO_KEY   = 2'd2;
    localparam logic [1:0] OP_START_DELAY = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_MACHINE_ON  = 3'd1;
    localparam logic [2:0] EV_MACHINE_OFF = 3'd2;
    localparam logic [2:0] EV_RADIO_ON    = 3'd3;
    localparam logic [2:0] EV_RADIO_OFF   = 3'd4;

    localparam logic [1:0] REG_SESSION_LIMIT = 2'd0;
    localparam logic [1:0] REG_TOTAL_LIMIT   = 2'd1;
    localparam logic [1:0] REG_DELAY_MINUTES = 2'd2;

    localparam logic [24:0] TICK_WRAP        = 25'd30000000;
    localparam logic [6:0]  TICKS_PER_SECOND = 7'd100;
    localparam logic [5:0]  LAST_UNIT        = 6'd59;
    localparam logic [10:0] HOLD_MIN         = 11'd500;
    localparam logic [10:0] HOLD_MAX         = 11'd2000;
    localparam logic [6:0]  DELAY_END_MIN    = 7'd80;

    localparam logic [15:0] SESSION_LIMIT_RESET = 16'd9999;
    localparam logic [23:0] TOTAL_LIMIT_RESET   = 24'hFFFFFF;

    typedef struct packed {
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [15:0] run_hours;
        logic [23:0] total_hours;
        logic        delay_active;
        logic [6:0]  delay_remaining;
    } clock_t;

endpackage

// ===== hw/rtl/runtime_clock_and_key_toggle.sv =====
// Top level of the run-time clock and key toggle block.
//
// Input channel s_*: one item per transfer, s_operation selects a 10 ms tick,
// a power-key edge, a bluetooth-key edge or a delay start; s_pin_level is the
// key pin (low pressed, high released). Every item gives exactly one result on
// the m_* channel: machine and bluetooth flags, the event code of the item,
// the free tick count, the run clock and the delay countdown after the item.
// Configuration: cfg_index/cfg_data written on a cfg_valid/cfg_ready transfer
// (0 session hour limit, 1 total hour limit, 2 delay minutes); always ready.
// Each result is registered in the output entry, or in the skid entry while the receiver holds the output entry.
// Throughput: one item per cycle while s_ready is high; all state is updated together at the input transfer.
// A two-entry output buffer holds results while the receiver stalls; s_ready
// drops only once both entries are full, and does not depend on m_ready.
// Reset clears all counters and flags and loads the register defaults.
module runtime_clock_and_key_toggle (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic        s_pin_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_machine_on,
    output logic        m_bluetooth_on,
    output logic [2:0]  m_event_code,
    output logic [24:0] m_free_ticks,
    output logic [5:0]  m_run_seconds,
    output logic [5:0]  m_run_minutes,
    output logic [15:0] m_run_hours,
    output logic [23:0] m_total_hours,
    output logic        m_delay_active,
    output logic [6:0]  m_delay_remaining,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import rtck_pkg::*;

    typedef struct packed {
        logic        machine_on;
        logic        bluetooth_on;
        logic [2:0]  event_code;
        logic [24:0] free_ticks;
        clock_t      clk;
    } result_t;

    logic [15:0] session_limit_reg;
    logic [23:0] total_limit_reg;
    logic [6:0]  delay_minutes_reg;

    logic [24:0] free_tick_reg, free_tick_next;
    logic [24:0] run_tick_reg, run_tick_next;
    logic [6:0]  sub_tick_reg, sub_tick_next;
    logic [10:0] hold_reg, hold_next;
    logic        power_held_reg, power_held_next;
    logic        radio_held_reg, radio_held_next;
    logic        running_reg, running_next;
    logic        radio_reg, radio_next;
    logic [2:0]  event_next;

    logic        accept;
    logic        second_step;
    logic        delay_start;
    clock_t      clk_next;
    result_t     result;

    result_t     out_reg;
    logic        out_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;
    logic        pop;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        free_tick_next  = free_tick_reg;
        run_tick_next   = run_tick_reg;
        sub_tick_next   = sub_tick_reg;
        hold_next       = hold_reg;
        power_held_next = power_held_reg;
        radio_held_next = radio_held_reg;
        running_next    = running_reg;
        radio_next      = radio_reg;
        event_next      = EV_NONE;
        second_step     = 1'b0;
        delay_start     = 1'b0;
        if (accept) begin
            unique case (s_operation)
                OP_TICK: begin
                    free_tick_next = (free_tick_reg >= TICK_WRAP) ? 25'd0
                                                                  : free_tick_reg + 25'd1;
                    if (running_reg) begin
                        if (run_tick_reg >= TICK_WRAP) begin
                            run_tick_next = '0;
                            sub_tick_next = '0;
                        end else begin
                            run_tick_next = run_tick_reg + 25'd1;
                            sub_tick_next = (sub_tick_reg == TICKS_PER_SECOND - 7'd1)
                                            ? 7'd0 : sub_tick_reg + 7'd1;
                        end
                        second_step = (sub_tick_next == 7'd0);
                    end
                    if (radio_held_reg) begin
                        hold_next = (hold_reg >= HOLD_MAX) ? HOLD_MAX : hold_reg + 11'd1;
                    end
                end
                OP_POWER_KEY: begin
                    if (!s_pin_level && !power_held_reg) begin
                        power_held_next = 1'b1;
                    end else if (s_pin_level && power_held_reg) begin
                        power_held_next = 1'b0;
                        running_next    = !running_reg;
                        event_next      = running_reg ? EV_MACHINE_OFF : EV_MACHINE_ON;
                    end
                end
                OP_RADIO_KEY: begin
                    if (!s_pin_level && !radio_held_reg) begin
                        radio_held_next = 1'b1;
                    end else if (s_pin_level && radio_held_reg) begin
                        radio_held_next = 1'b0;
                        hold_next       = '0;
                        if (hold_reg >= HOLD_MIN) begin
                            radio_next = !radio_reg;
                            event_next = radio_reg ? EV_RADIO_OFF : EV_RADIO_ON;
                        end
                    end
                end
                OP_START_DELAY: begin
                    delay_start = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    rtck_run_clock u_run_clock (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .second_step   (second_step),
        .delay_start   (delay_start),
        .session_limit (session_limit_reg),
        .total_limit   (total_limit_reg),
        .delay_minutes (delay_minutes_reg),
        .clk_next      (clk_next)
    );

    assign result.machine_on   = running_next;
    assign result.bluetooth_on = radio_next;
    assign result.event_code   = event_next;
    assign result.free_ticks   = free_tick_next;
    assign result.clk          = clk_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_limit_reg <= SESSION_LIMIT_RESET;
            total_limit_reg   <= TOTAL_LIMIT_RESET;
            delay_minutes_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SESSION_LIMIT: session_limit_reg <= cfg_data[15:0];
                REG_TOTAL_LIMIT:   total_limit_reg   <= cfg_data;
                REG_DELAY_MINUTES: delay_minutes_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_tick_reg  <= '0;
            run_tick_reg   <= '0;
            sub_tick_reg   <= '0;
            hold_reg       <= '0;
            power_held_reg <= 1'b0;
            radio_held_reg <= 1'b0;
            running_reg    <= 1'b0;
            radio_reg      <= 1'b0;
        end else begin
            free_tick_reg  <= free_tick_next;
            run_tick_reg   <= run_tick_next;
            sub_tick_reg   <= sub_tick_next;
            hold_reg       <= hold_next;
            power_held_reg <= power_held_next;
            radio_held_reg <= radio_held_next;
            running_reg    <= running_next;
            radio_reg      <= radio_next;
        end
    end

    assign pop     = out_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (accept) begin
                    skid_reg <= result;
                end
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_machine_on      = out_reg.machine_on;
    assign m_bluetooth_on    = out_reg.bluetooth_on;
    assign m_event_code      = out_reg.event_code;
    assign m_free_ticks      = out_reg.free_ticks;
    assign m_run_seconds     = out_reg.clk.seconds;
    assign m_run_minutes     = out_reg.clk.minutes;
    assign m_run_hours       = out_reg.clk.run_hours;
    assign m_total_hours     = out_reg.clk.total_hours;
    assign m_delay_active    = out_reg.clk.delay_active;
    assign m_delay_remaining = out_reg.clk.delay_remaining;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    a_hold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg <= HOLD_MAX && sub_tick_reg < TICKS_PER_SECOND)
        else $error("hold or sub-second count out of range");

    a_hold_only_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !radio_held_reg |-> hold_reg == 11'd0)
        else $error("hold time counted without key held");

    a_event_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.event_code == EV_MACHINE_ON |-> out_reg.machine_on)
        else $error("machine on event with machine flag low");

endmodule

// ===== hw/rtl/rtck_run_clock.sv =====
// Run clock: seconds, minutes, saturating hours and the delay countdown.
module rtck_run_clock (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 second_step,
    input  logic                 delay_start,
    input  logic [15:0]          session_limit,
    input  logic [23:0]          total_limit,
    input  logic [6:0]           delay_minutes,
    output rtck_pkg::clock_t     clk_next
);
    import rtck_pkg::*;

    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [15:0] sess_reg, sess_next;
    logic [23:0] tot_reg, tot_next;
    logic        dly_run_reg, dly_run_next;
    logic [5:0]  dly_sec_reg, dly_sec_next;
    logic [6:0]  dly_min_reg, dly_min_next;
    logic [6:0]  dly_left_reg, dly_left_next;

    always_comb begin
        sec_next      = sec_reg;
        min_next      = min_reg;
        sess_next     = sess_reg;
        tot_next      = tot_reg;
        dly_run_next  = dly_run_reg;
        dly_sec_next  = dly_sec_reg;
        dly_min_next  = dly_min_reg;
        dly_left_next = dly_left_reg;
        if (second_step) begin
            if (sec_reg == LAST_UNIT) begin
                sec_next = '0;
                if (min_reg == LAST_UNIT) begin
                    min_next  = '0;
                    sess_next = (sess_reg >= session_limit) ? session_limit
                                                            : sess_reg + 16'd1;
                    tot_next  = (tot_reg >= total_limit) ? total_limit
                                                         : tot_reg + 24'd1;
                end else begin
                    min_next = min_reg + 6'd1;
                end
            end else begin
                sec_next = sec_reg + 6'd1;
            end
            if (dly_run_reg) begin
                if (dly_sec_reg == LAST_UNIT) begin
                    dly_sec_next = '0;
                    dly_min_next = dly_min_reg + 7'd1;
                end else begin
                    dly_sec_next = dly_sec_reg + 6'd1;
                end
                dly_left_next = (dly_min_next >= delay_minutes) ? 7'd0
                                                                : delay_minutes - dly_min_next;
                if (dly_min_next == DELAY_END_MIN && dly_sec_next == 6'd0) begin
                    dly_min_next = '0;
                    dly_run_next = 1'b0;
                end
            end
        end else if (delay_start) begin
            dly_run_next  = 1'b1;
            dly_sec_next  = '0;
            dly_min_next  = '0;
            dly_left_next = delay_minutes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg      <= '0;
            min_reg      <= '0;
            sess_reg     <= '0;
            tot_reg      <= '0;
            dly_run_reg  <= 1'b0;
            dly_sec_reg  <= '0;
            dly_min_reg  <= '0;
            dly_left_reg <= '0;
        end else begin
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            sess_reg     <= sess_next;
            tot_reg      <= tot_next;
            dly_run_reg  <= dly_run_next;
            dly_sec_reg  <= dly_sec_next;
            dly_min_reg  <= dly_min_next;
            dly_left_reg <= dly_left_next;
        end
    end

    assign clk_next.seconds         = sec_next;
    assign clk_next.minutes         = min_next;
    assign clk_next.run_hours       = sess_next;
    assign clk_next.total_hours     = tot_next;
    assign clk_next.delay_active    = dly_run_next;
    assign clk_next.delay_remaining = dly_left_next;

    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_reg <= LAST_UNIT && min_reg <= LAST_UNIT && dly_sec_reg <= LAST_UNIT)
        else $error("run clock unit out of range");

    a_delay_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !dly_run_reg |-> (dly_min_reg == 7'd0 && dly_sec_reg == 6'd0))
        else $error("delay counters not cleared while idle");

endmodule

// ===== bench/rtck_result_check.sv =====
`timescale 1ns / 1ps
// Result checker for the run-time clock and key toggle block: predicts and compares results.
module rtck_result_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic        s_pin_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_machine_on,
    input  logic        m_bluetooth_on,
    input  logic [2:0]  m_event_code,
    input  logic [24:0] m_free_ticks,
    input  logic [5:0]  m_run_seconds,
    input  logic [5:0]  m_run_minutes,
    input  logic [15:0] m_run_hours,
    input  logic [23:0] m_total_hours,
    input  logic        m_delay_active,
    input  logic [6:0]  m_delay_remaining,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          pending,
    output int          fail_count
);
    import rtck_pkg::*;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int DELAY_END_SECONDS  = 4800;

    typedef struct packed {
        logic        machine_on;
        logic        bluetooth_on;
        logic [2:0]  event_code;
        logic [24:0] free_ticks;
        logic [5:0]  run_seconds;
        logic [5:0]  run_minutes;
        logic [15:0] run_hours;
        logic [23:0] total_hours;
        logic        delay_active;
        logic [6:0]  delay_remaining;
    } status_t;

    logic [15:0] session_hour_cap;
    logic [23:0] total_hour_cap;
    logic [6:0]  delay_length;

    logic [24:0] free_ticks_now;
    logic [24:0] run_ticks_now;
    logic [10:0] hold_ticks;
    logic [5:0]  clock_seconds;
    logic [5:0]  clock_minutes;
    logic [15:0] session_hrs;
    logic [23:0] total_hrs;
    logic [12:0] delay_secs;
    logic        delay_counting;
    logic        power_pressed;
    logic        radio_pressed;
    logic        machine_running;
    logic        radio_enabled;
    logic [6:0]  delay_minutes_left;

    status_t status_due[$];

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    function automatic logic [24:0] next_tick(logic [24:0] count);
        return (count >= TICK_WRAP) ? 25'd0 : count + 25'd1;
    endfunction

    function automatic int unsigned saturate_up(int unsigned count, int unsigned cap);
        return (count >= cap) ? cap : count + 1;
    endfunction

    function automatic status_t apply_item(logic [1:0] op, logic released);
        status_t     st;
        logic [2:0]  ev;
        int unsigned done_min;
        ev = EV_NONE;
        case (op)
            OP_TICK: begin
                free_ticks_now = next_tick(free_ticks_now);
                if (machine_running)
                    run_ticks_now = next_tick(run_ticks_now);
                if (radio_pressed)
                    hold_ticks = 11'(saturate_up(hold_ticks, HOLD_MAX));
                if (machine_running && (run_ticks_now % TICKS_PER_SECOND) == 0) begin
                    clock_seconds = clock_seconds + 6'd1;
                    if (clock_seconds >= SECONDS_PER_MINUTE) begin
                        clock_seconds = '0;
                        clock_minutes = clock_minutes + 6'd1;
                        if (clock_minutes >= MINUTES_PER_HOUR) begin
                            clock_minutes = '0;
                            session_hrs = 16'(saturate_up(session_hrs, session_hour_cap));
                            total_hrs   = 24'(saturate_up(total_hrs, total_hour_cap));
                        end
                    end
                    if (delay_counting) begin
                        delay_secs = delay_secs + 13'd1;
                        done_min   = delay_secs / SECONDS_PER_MINUTE;
                        if (delay_length == 0 || done_min >= delay_length)
                            delay_minutes_left = '0;
                        else
                            delay_minutes_left = 7'(delay_length - done_min);
                        if (delay_secs >= DELAY_END_SECONDS) begin
                            delay_secs     = '0;
                            delay_counting = 1'b0;
                        end
                    end
                end
            end
            OP_POWER_KEY: begin
                if (!released && !power_pressed) begin
                    power_pressed = 1'b1;
                end else if (released && power_pressed) begin
                    power_pressed   = 1'b0;
                    machine_running = !machine_running;
                    ev = machine_running ? EV_MACHINE_ON : EV_MACHINE_OFF;
                end
            end
            OP_RADIO_KEY: begin
                if (!released && !radio_pressed) begin
                    radio_pressed = 1'b1;
                end else if (released && radio_pressed) begin
                    radio_pressed = 1'b0;
                    if (hold_ticks >= HOLD_MIN) begin
                        radio_enabled = !radio_enabled;
                        ev = radio_enabled ? EV_RADIO_ON : EV_RADIO_OFF;
                    end
                    hold_ticks = '0;
                end
            end
            OP_START_DELAY: begin
                delay_counting     = 1'b1;
                delay_secs         = '0;
                delay_minutes_left = delay_length;
            end
        endcase
        st.machine_on      = machine_running;
        st.bluetooth_on    = radio_enabled;
        st.event_code      = ev;
        st.free_ticks      = free_ticks_now;
        st.run_seconds     = clock_seconds;
        st.run_minutes     = clock_minutes;
        st.run_hours       = session_hrs;
        st.total_hours     = total_hrs;
        st.delay_active    = delay_counting;
        st.delay_remaining = delay_minutes_left;
        return st;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(string name, logic [24:0] got, logic [24:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin : watch
        status_t want;
        if (!aresetn) begin
            session_hour_cap   = SESSION_LIMIT_RESET;
            total_hour_cap     = TOTAL_LIMIT_RESET;
            delay_length       = '0;
            free_ticks_now     = '0;
            run_ticks_now      = '0;
            hold_ticks         = '0;
            clock_seconds      = '0;
            clock_minutes      = '0;
            session_hrs        = '0;
            total_hrs          = '0;
            delay_secs         = '0;
            delay_counting     = 1'b0;
            power_pressed      = 1'b0;
            radio_pressed      = 1'b0;
            machine_running    = 1'b0;
            radio_enabled      = 1'b0;
            delay_minutes_left = '0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SESSION_LIMIT: session_hour_cap = cfg_data[15:0];
                    REG_TOTAL_LIMIT:   total_hour_cap   = cfg_data;
                    REG_DELAY_MINUTES: delay_length     = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                status_due.push_back(apply_item(s_operation, s_pin_level));
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    report_mismatch("result transfer with no item outstanding");
                end else begin
                    want = status_due.pop_front();
                    check_field("machine_on", m_machine_on, want.machine_on);
                    check_field("bluetooth_on", m_bluetooth_on, want.bluetooth_on);
                    check_field("event_code", m_event_code, want.event_code);
                    check_field("free_ticks", m_free_ticks, want.free_ticks);
                    check_field("run_seconds", m_run_seconds, want.run_seconds);
                    check_field("run_minutes", m_run_minutes, want.run_minutes);
                    check_field("run_hours", m_run_hours, want.run_hours);
                    check_field("total_hours", m_total_hours, want.total_hours);
                    check_field("delay_active", m_delay_active, want.delay_active);
                    check_field("delay_remaining", m_delay_remaining, want.delay_remaining);
                end
            end
        end
        pending <= status_due.size();
    end

endmodule

// ===== bench/runtime_clock_and_key_toggle_test.sv =====
`timescale 1ns / 1ps
// Test top for the run-time clock and key toggle block: stimulus, watchdog and verdict.
module runtime_clock_and_key_toggle_test;
    import rtck_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEM_TARGET     = 800;
    localparam int RANDOM_PHASES   = 4;
    localparam int LONG_HOLD_TICKS = 510;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic [1:0]  s_operation = OP_TICK;
    logic        s_pin_level = 1'b0;
    logic        m_ready     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = REG_SESSION_LIMIT;
    logic [23:0] cfg_data    = '0;

    logic        s_ready;
    logic        m_valid;
    logic        m_machine_on;
    logic        m_bluetooth_on;
    logic [2:0]  m_event_code;
    logic [24:0] m_free_ticks;
    logic [5:0]  m_run_seconds;
    logic [5:0]  m_run_minutes;
    logic [15:0] m_run_hours;
    logic [23:0] m_total_hours;
    logic        m_delay_active;
    logic [6:0]  m_delay_remaining;
    logic        cfg_ready;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    int items_sent  = 0;
    bit full_speed  = 1'b0;

    runtime_clock_and_key_toggle dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_pin_level       (s_pin_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_machine_on      (m_machine_on),
        .m_bluetooth_on    (m_bluetooth_on),
        .m_event_code      (m_event_code),
        .m_free_ticks      (m_free_ticks),
        .m_run_seconds     (m_run_seconds),
        .m_run_minutes     (m_run_minutes),
        .m_run_hours       (m_run_hours),
        .m_total_hours     (m_total_hours),
        .m_delay_active    (m_delay_active),
        .m_delay_remaining (m_delay_remaining),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    rtck_result_check result_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_pin_level       (s_pin_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_machine_on      (m_machine_on),
        .m_bluetooth_on    (m_bluetooth_on),
        .m_event_code      (m_event_code),
        .m_free_ticks      (m_free_ticks),
        .m_run_seconds     (m_run_seconds),
        .m_run_minutes     (m_run_minutes),
        .m_run_hours       (m_run_hours),
        .m_total_hours     (m_total_hours),
        .m_delay_active    (m_delay_active),
        .m_delay_remaining (m_delay_remaining),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .pending           (pending),
        .fail_count        (fail_count)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 999);
        if (r < 700)
            return 0;
        if (r < 950)
            return $urandom_range(1, 3);
        if (r < 995)
            return $urandom_range(4, 15);
        return $urandom_range(30, 100);
    endfunction

    function automatic int unsigned pick_value(int unsigned top_value);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top_value;
            default: return $urandom_range(0, top_value);
        endcase
    endfunction

    initial begin : result_stalls
        int gap;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic pin);
        int gap;
        gap = full_speed ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_pin_level <= pin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_ticks(int count);
        for (int i = 0; i < count; i++)
            send_item(OP_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(int unsigned session_cap, int unsigned total_cap,
                             int unsigned delay_len);
        drain();
        write_reg(REG_SESSION_LIMIT, 24'(session_cap));
        write_reg(REG_TOTAL_LIMIT, 24'(total_cap));
        write_reg(REG_DELAY_MINUTES, 24'(delay_len));
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int pick;
        int hold;
        int phase_end;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every operation, both pin levels, repeated edges, short hold
        send_item(OP_TICK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_START_DELAY, 1'b0);
        send_item(OP_POWER_KEY, 1'b1);
        send_item(OP_POWER_KEY, 1'b0);
        send_item(OP_POWER_KEY, 1'b0);
        send_item(OP_POWER_KEY, 1'b1);
        send_item(OP_RADIO_KEY, 1'b1);
        send_item(OP_RADIO_KEY, 1'b0);
        send_item(OP_RADIO_KEY, 1'b0);
        send_ticks(3);
        send_item(OP_RADIO_KEY, 1'b1);
        send_ticks(4);
        send_item(OP_POWER_KEY, 1'b0);
        send_item(OP_POWER_KEY, 1'b1);
        send_item(OP_POWER_KEY, 1'b1);
        send_item(OP_START_DELAY, 1'b1);

        // long bluetooth hold while running, past the toggle threshold
        configure(0, 24'hFFFFFF, 80);
        full_speed = 1'b1;
        send_item(OP_POWER_KEY, 1'b0);
        send_item(OP_POWER_KEY, 1'b1);
        send_item(OP_RADIO_KEY, 1'b0);
        send_item(OP_START_DELAY, 1'b0);
        send_ticks(LONG_HOLD_TICKS);
        send_item(OP_RADIO_KEY, 1'b1);
        full_speed = 1'b0;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - phase);
            if (phase == 0)
                configure(16'hFFFF, 0, 0);
            else
                configure(pick_value(16'hFFFF), pick_value(24'hFFFFFF), pick_value(80));
            while (items_sent < phase_end) begin
                full_speed = ($urandom_range(0, 9) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    send_ticks($urandom_range(1, 20));
                end else if (pick < 45) begin
                    send_item(OP_POWER_KEY, 1'b0);
                    if ($urandom_range(0, 3) == 0)
                        send_item(OP_POWER_KEY, 1'b0);
                    send_ticks($urandom_range(0, 3));
                    send_item(OP_POWER_KEY, 1'b1);
                    if ($urandom_range(0, 4) == 0)
                        send_item(OP_POWER_KEY, 1'b1);
                end else if (pick < 55) begin
                    hold = $urandom_range(0, 30);
                    send_item(OP_RADIO_KEY, 1'b0);
                    if ($urandom_range(0, 3) == 0)
                        send_item(OP_RADIO_KEY, 1'b0);
                    send_ticks(hold);
                    send_item(OP_RADIO_KEY, 1'b1);
                    if ($urandom_range(0, 4) == 0)
                        send_item(OP_RADIO_KEY, 1'b1);
                end else if (pick < 65) begin
                    send_item(OP_START_DELAY, 1'($urandom_range(0, 1)));
                end else if (pick < 80) begin
                    send_item(OP_TICK, 1'($urandom_range(0, 1)));
                end else begin
                    send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                end
            end
        end
        full_speed = 1'b0;

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
